/* rtl/char_lcd_write_sequencer_macros.svh */
// Assertion macros shared by the character-LCD write sequencer RTL.
`ifndef CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLWS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clws assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clws assertion failed");

`endif

/* rtl/clws_pkg.sv */
// Types, request codes and constants for the character-LCD write sequencer.
package clws_pkg;

  // request kinds
  localparam logic [2:0] REQ_INIT = 3'd0;
  localparam logic [2:0] REQ_CMD  = 3'd1;
  localparam logic [2:0] REQ_DATA = 3'd2;
  localparam logic [2:0] REQ_CHAR = 3'd3;
  localparam logic [2:0] REQ_INT  = 3'd4;

  localparam logic       RS_CMD  = 1'b0;
  localparam logic       RS_DATA = 1'b1;

  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;   // '0' is 0x30
  localparam logic [2:0] LAST_DIGIT     = 3'd4;   // units digit

  localparam int         QDEPTH = 2;
  localparam int         QPTR_W = $clog2(QDEPTH);

  // one classified item as held in the queue
  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        addr;      // set-address command
    logic [7:0]        data;      // command or character byte
    logic [0:4][3:0]   digits;    // BCD, most significant first
    logic [2:0]        first;     // index of first shown digit
  } clws_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } clws_qstat_t;

  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h38;   // 8-bit bus, two lines, 5x8 font
      2'd1:    c = 8'h0C;   // display on, cursor off
      2'd2:    c = 8'h06;   // entry mode: increment
      default: c = 8'h01;   // clear display
    endcase
    return c;
  endfunction

endpackage

/* rtl/clws_front.sv */
// Front end: takes requests, forms the address and converts integers to BCD.
module clws_front #(
  parameter int ROW_COLUMNS = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_req_type,
  input  logic [5:0]           in_column,
  input  logic                 in_row,
  input  logic [7:0]           in_byte_value,
  input  logic [15:0]          in_number,
  input  clws_pkg::clws_qstat_t qstat,
  output logic                 push,
  output clws_pkg::clws_desc_t desc
);

  // four double-dabble bit steps on {bcd, bin}
  function automatic logic [35:0] dd_step4(input logic [35:0] s);
    logic [35:0] t;
    t = s;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 5; j++) begin
        if (t[16 + 4*j +: 4] >= 4'd5) begin
          t[16 + 4*j +: 4] = t[16 + 4*j +: 4] + 4'd3;
        end
      end
      t = {t[34:0], 1'b0};
    end
    return t;
  endfunction

  logic        fv_r;
  logic        conv_r;
  logic [1:0]  cnt_r;
  logic [2:0]  kind_r;
  logic [7:0]  addr_r;
  logic [7:0]  data_r;
  logic [15:0] bin_r;
  logic [19:0] bcd_r;

  logic        accept;
  logic        known;
  logic [5:0]  col_sat;
  logic [0:4][3:0] dig;

  assign known   = (in_req_type <= clws_pkg::REQ_INT);
  assign col_sat = (in_column >= 6'(ROW_COLUMNS)) ? 6'(ROW_COLUMNS - 1) : in_column;
  assign push    = fv_r && !conv_r && !qstat.full;
  assign busy    = fv_r && !push;
  assign accept  = start && !busy;
  assign dig     = bcd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r   <= 1'b0;
      conv_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (accept) begin
      fv_r   <= known;
      conv_r <= (in_req_type == clws_pkg::REQ_INT);
      cnt_r  <= 2'd3;
    end else if (push) begin
      fv_r <= 1'b0;
    end else if (conv_r) begin
      if (cnt_r == 2'd0) begin
        conv_r <= 1'b0;
      end
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_req_type;
      // row base 0x00 / 0x40 is the row bit above the six column bits
      addr_r <= {1'b1, in_row, col_sat};
      data_r <= in_byte_value;
      bin_r  <= in_number;
      bcd_r  <= '0;
    end else if (conv_r) begin
      {bcd_r, bin_r} <= dd_step4({bcd_r, bin_r});
    end
  end

  always_comb begin
    desc.kind   = kind_r;
    desc.addr   = addr_r;
    desc.data   = data_r;
    desc.digits = dig;
    if (dig[0] != 4'd0) begin
      desc.first = 3'd0;
    end else if (dig[1] != 4'd0) begin
      desc.first = 3'd1;
    end else if (dig[2] != 4'd0) begin
      desc.first = 3'd2;
    end else if (dig[3] != 4'd0) begin
      desc.first = 3'd3;
    end else begin
      desc.first = clws_pkg::LAST_DIGIT;
    end
  end

endmodule

/* rtl/clws_queue.sv */
// Two-entry item queue between the front end and the bus write sequencer.
module clws_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  clws_pkg::clws_desc_t  wdata,
  input  logic                  pop,
  output clws_pkg::clws_desc_t  rdata,
  output clws_pkg::clws_qstat_t qstat
);

  clws_pkg::clws_desc_t mem [0:clws_pkg::QDEPTH-1];

  logic [clws_pkg::QPTR_W-1:0] wp_r;
  logic [clws_pkg::QPTR_W-1:0] rp_r;
  logic [clws_pkg::QPTR_W:0]   cnt_r;

  assign qstat.full  = (cnt_r == (clws_pkg::QPTR_W + 1)'(clws_pkg::QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign rdata       = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/clws_back.sv */
// Back end: steps through the head item, one registered bus write per cycle.
`include "char_lcd_write_sequencer_macros.svh"

module clws_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  clws_pkg::clws_desc_t  head,
  input  clws_pkg::clws_qstat_t qstat,
  output logic                  pop,
  output logic                  out_strobe,
  output logic                  out_reg_select,
  output logic [7:0]            out_bus_byte,
  output logic                  out_last
);

  logic [2:0] step_r;
  logic [2:0] step_nxt;
  logic       strobe_r;
  logic       rs_r;
  logic [7:0] byte_r;
  logic       last_r;

  logic       rs_c;
  logic [7:0] byte_c;
  logic       last_c;
  logic [2:0] idx;
  logic       int_digit;

  assign idx = head.first + step_r - 3'd1;

  // a digit write of an integer item is under way
  assign int_digit = !qstat.empty && (head.kind == clws_pkg::REQ_INT) && (step_r != 3'd0);

  always_comb begin
    rs_c   = clws_pkg::RS_CMD;
    byte_c = head.addr;
    last_c = 1'b0;
    unique case (head.kind)
      clws_pkg::REQ_INIT: begin
        byte_c = clws_pkg::init_cmd(step_r[1:0]);
        last_c = (step_r == 3'd3);
      end
      clws_pkg::REQ_CMD: begin
        byte_c = head.data;
        last_c = 1'b1;
      end
      clws_pkg::REQ_DATA: begin
        rs_c   = clws_pkg::RS_DATA;
        byte_c = head.data;
        last_c = 1'b1;
      end
      clws_pkg::REQ_CHAR: begin
        if (step_r != 3'd0) begin
          rs_c   = clws_pkg::RS_DATA;
          byte_c = head.data;
          last_c = 1'b1;
        end
      end
      clws_pkg::REQ_INT: begin
        if (step_r != 3'd0) begin
          rs_c   = clws_pkg::RS_DATA;
          byte_c = {clws_pkg::ASCII_DIGIT_HI, head.digits[idx]};
          last_c = (idx == clws_pkg::LAST_DIGIT);
        end
      end
      default: begin
        last_c = 1'b1;
      end
    endcase
  end

  assign pop = !qstat.empty && last_c;

  always_comb begin
    if (pop) begin
      step_nxt = 3'd0;
    end else if (!qstat.empty) begin
      step_nxt = step_r + 3'd1;
    end else begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 3'd0;
      strobe_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      strobe_r <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    rs_r   <= rs_c;
    byte_r <= byte_c;
    last_r <= last_c;
  end

  assign out_strobe     = strobe_r;
  assign out_reg_select = rs_r;
  assign out_bus_byte   = byte_r;
  assign out_last       = last_r;

  `CLWS_ASSERT_NEXT(a_run_continues, strobe_r && !last_r, strobe_r)
  `CLWS_ASSERT_NOW(a_mid_item_held, step_r != 3'd0, !qstat.empty)
  `CLWS_ASSERT_NOW(a_digit_in_range, int_digit, idx <= clws_pkg::LAST_DIGIT)

endmodule

/* rtl/char_lcd_write_sequencer.sv */
// Top level: character-LCD write sequencer, request in, bus writes out.
// Path: the front end registers an accepted request and pushes it into the queue, and the back end
//   registers each write; an integer request first runs BCD conversion (4 bits per cycle) in the front end.
// Throughput: the back end emits one bus write per cycle while an item is queued (1 to 6 per item);
//   the front takes an item per cycle while the queue is not full, held off (busy) during an integer conversion.
// Reset: rst_n synchronous, active low; clears queue pointers and sequencing state.
// The receiver cannot stall: each write is on the out_ ports for one cycle only.
module char_lcd_write_sequencer #(
  parameter int ROW_COLUMNS = 40   // columns per row, 16 to 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [5:0]  in_column,
  input  logic        in_row,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_number,
  output logic        out_strobe,
  output logic        out_reg_select,
  output logic [7:0]  out_bus_byte,
  output logic        out_last
);

  // Front end classifies each item: unknown kinds are dropped here, positions
  // become a set-address byte (column saturated to the row length), and an
  // integer is turned into five BCD digits with the first shown digit marked.
  clws_pkg::clws_desc_t  f_desc;
  clws_pkg::clws_desc_t  q_head;
  clws_pkg::clws_qstat_t qstat;
  logic                  push;
  logic                  pop;

  clws_front #(
    .ROW_COLUMNS (ROW_COLUMNS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_byte_value (in_byte_value),
    .in_number     (in_number),
    .qstat         (qstat),
    .push          (push),
    .desc          (f_desc)
  );

  // Short queue so a long integer conversion and a long write run overlap.
  clws_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_desc),
    .pop   (pop),
    .rdata (q_head),
    .qstat (qstat)
  );

  // Back end walks the head item, one registered write per cycle, and pops it
  // on the write flagged last.
  clws_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .qstat          (qstat),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_reg_select (out_reg_select),
    .out_bus_byte   (out_bus_byte),
    .out_last       (out_last)
  );

endmodule

/* test/char_lcd_write_sequencer_checker.sv */
// Checker for the LCD write sequencer: predicts each request's bus writes and compares them.
`timescale 1ns / 1ps

module char_lcd_write_sequencer_checker #(
  parameter int ROW_COLUMNS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [5:0]  in_column,
  input  logic        in_row,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_number,
  input  logic        out_strobe,
  input  logic        out_reg_select,
  input  logic [7:0]  out_bus_byte,
  input  logic        out_last,
  output int          mismatches,
  output int          writes_pending,
  output int          writes_checked
);

  localparam logic [7:0] LCD_FUNCTION_SET = 8'h38;
  localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] LCD_CLEAR        = 8'h01;
  localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
  localparam logic [7:0] ROW0_BASE        = 8'h00;
  localparam logic [7:0] ROW1_BASE        = 8'h40;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       wr_last;
  } bus_write_t;

  bus_write_t writes_due[$];

  // queue the bus writes one request should produce, in bus order
  function automatic void queue_bus_writes(input logic [2:0] kind, input logic [5:0] col,
                                           input logic rw, input logic [7:0] byt,
                                           input logic [15:0] num);
    bus_write_t burst[$];
    logic [7:0] addr_cmd;
    int         col_sat;
    int         val;
    int         place;
    int         digit;
    bit         shown;
    col_sat  = (col >= ROW_COLUMNS) ? ROW_COLUMNS - 1 : int'(col);
    addr_cmd = LCD_SET_DDRAM | ((rw ? ROW1_BASE : ROW0_BASE) + 8'(col_sat));
    case (kind)
      clws_pkg::REQ_INIT: begin
        burst.push_back('{clws_pkg::RS_CMD, LCD_FUNCTION_SET, 1'b0});
        burst.push_back('{clws_pkg::RS_CMD, LCD_DISPLAY_ON, 1'b0});
        burst.push_back('{clws_pkg::RS_CMD, LCD_ENTRY_MODE, 1'b0});
        burst.push_back('{clws_pkg::RS_CMD, LCD_CLEAR, 1'b0});
      end
      clws_pkg::REQ_CMD:  burst.push_back('{clws_pkg::RS_CMD, byt, 1'b0});
      clws_pkg::REQ_DATA: burst.push_back('{clws_pkg::RS_DATA, byt, 1'b0});
      clws_pkg::REQ_CHAR: begin
        burst.push_back('{clws_pkg::RS_CMD, addr_cmd, 1'b0});
        burst.push_back('{clws_pkg::RS_DATA, byt, 1'b0});
      end
      clws_pkg::REQ_INT: begin
        burst.push_back('{clws_pkg::RS_CMD, addr_cmd, 1'b0});
        val   = int'(num);
        place = 10000;
        shown = 1'b0;
        // leading zeros dropped; units digit always shown
        while (place > 0) begin
          digit = (val / place) % 10;
          if (digit != 0 || shown || place == 1) begin
            shown = 1'b1;
            burst.push_back('{clws_pkg::RS_DATA, ASCII_ZERO + 8'(digit), 1'b0});
          end
          place = place / 10;
        end
      end
      default: ;  // unused kinds are dropped
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].wr_last = 1'b1;
    foreach (burst[i]) writes_due.push_back(burst[i]);
  endfunction

  always @(posedge clk) begin : watch
    bus_write_t due;
    if (!rst_n) begin
      writes_due.delete();
    end else begin
      // compare before queueing: a write at this edge never belongs to this edge's request
      if (out_strobe) begin
        if (writes_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected bus write, expected none, got rs=%0b byte=%02h last=%0b",
                   $time, out_reg_select, out_bus_byte, out_last);
        end else begin
          due = writes_due.pop_front();
          writes_checked++;
          if (out_reg_select !== due.rs) begin
            mismatches++;
            $display("%0t ns: reg_select expected %0b, got %0b",
                     $time, due.rs, out_reg_select);
          end
          if (out_bus_byte !== due.data) begin
            mismatches++;
            $display("%0t ns: bus_byte expected %02h, got %02h",
                     $time, due.data, out_bus_byte);
          end
          if (out_last !== due.wr_last) begin
            mismatches++;
            $display("%0t ns: last expected %0b, got %0b", $time, due.wr_last, out_last);
          end
        end
      end
      if (start && !busy)
        queue_bus_writes(in_req_type, in_column, in_row, in_byte_value, in_number);
    end
    writes_pending = writes_due.size();
  end

endmodule

/* test/char_lcd_write_sequencer_tb.sv */
// Testbench top for the LCD write sequencer: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module char_lcd_write_sequencer_tb;

  localparam int         ROW_COLUMNS     = 40;
  localparam int         ITEMS_PER_PHASE = 80;       // four phases, about 350 requests
  localparam int         SETTLE_CYCLES   = 16;       // covers BCD conversion plus six writes
  localparam int         LIMIT_CYCLES    = 200000;   // far beyond the slowest correct run
  // request kinds the block has no use for; it must swallow them silently
  localparam logic [2:0] REQ_SPARE_LO    = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI    = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_req_type;
  logic [5:0]  in_column;
  logic        in_row;
  logic [7:0]  in_byte_value;
  logic [15:0] in_number;
  logic        out_strobe;
  logic        out_reg_select;
  logic [7:0]  out_bus_byte;
  logic        out_last;

  int mismatches;
  int writes_pending;
  int writes_checked;
  int cycles;
  int idle_pct;      // chance, in percent, that the sender idles for a cycle
  int reqs_sent;     // requests of a real kind
  int reqs_ignored;  // requests of an unused kind

  always #5 clk = ~clk;

  char_lcd_write_sequencer #(
    .ROW_COLUMNS(ROW_COLUMNS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_byte_value (in_byte_value),
    .in_number     (in_number),
    .out_strobe    (out_strobe),
    .out_reg_select(out_reg_select),
    .out_bus_byte  (out_bus_byte),
    .out_last      (out_last)
  );

  char_lcd_write_sequencer_checker #(
    .ROW_COLUMNS(ROW_COLUMNS)
  ) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_byte_value (in_byte_value),
    .in_number     (in_number),
    .out_strobe    (out_strobe),
    .out_reg_select(out_reg_select),
    .out_bus_byte  (out_bus_byte),
    .out_last      (out_last),
    .mismatches    (mismatches),
    .writes_pending(writes_pending),
    .writes_checked(writes_checked)
  );

  // watchdog: a hung handshake or a missing write ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d bus writes still due", cycles, writes_pending);
      $display("FAIL");
      $finish;
    end
  end

  // Offer one request. Called at a falling edge and returns at a falling edge,
  // so start is assigned once per step and never dropped between back-to-back items.
  // Idle cycles carry random junk on the fields with start low.
  task automatic send_req(input logic [2:0] kind, input logic [5:0] col, input logic rw,
                          input logic [7:0] byt, input logic [15:0] num);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start         <= 1'b0;
      in_req_type   <= 3'($urandom);
      in_column     <= 6'($urandom);
      in_row        <= 1'($urandom);
      in_byte_value <= 8'($urandom);
      in_number     <= 16'($urandom);
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= kind;
    in_column     <= col;
    in_row        <= rw;
    in_byte_value <= byt;
    in_number     <= num;
    // accepted at the first rising edge that sees busy low
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (kind > clws_pkg::REQ_INT) reqs_ignored++;
    else reqs_sent++;
  endtask

  initial begin
    int          pick;
    int          counted;
    int          ndig;
    int          num_i;
    logic [2:0]  kind;
    logic [5:0]  col;
    logic        rw;
    logic [7:0]  byt;
    logic [15:0] num;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = clws_pkg::REQ_INIT;
    in_column     = '0;
    in_row        = 1'b0;
    in_byte_value = '0;
    in_number     = '0;
    idle_pct      = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed corners, back to back ---
    send_req(clws_pkg::REQ_INIT, 6'd0,  1'b0, 8'h00, 16'd0);
    send_req(clws_pkg::REQ_CMD,  6'd63, 1'b1, 8'h00, 16'hFFFF);  // unused fields all ones
    send_req(clws_pkg::REQ_CMD,  6'd0,  1'b0, 8'hFF, 16'd0);
    send_req(clws_pkg::REQ_DATA, 6'd0,  1'b0, 8'h00, 16'd0);
    send_req(clws_pkg::REQ_DATA, 6'd63, 1'b1, 8'hFF, 16'hFFFF);
    send_req(clws_pkg::REQ_DATA, 6'd21, 1'b0, 8'hA5, 16'h5A5A);
    send_req(clws_pkg::REQ_CHAR, 6'd0,  1'b0, 8'h41, 16'd0);     // home of the first row
    send_req(clws_pkg::REQ_CHAR, 6'd39, 1'b1, 8'h5A, 16'd0);     // last column, second row
    send_req(clws_pkg::REQ_CHAR, 6'd40, 1'b0, 8'h30, 16'd0);     // one past the row: clamps
    send_req(clws_pkg::REQ_CHAR, 6'd63, 1'b1, 8'hFF, 16'hFFFF);  // widest column: clamps
    send_req(clws_pkg::REQ_INT,  6'd0,  1'b0, 8'h00, 16'd0);     // zero shows a single digit
    send_req(clws_pkg::REQ_INT,  6'd39, 1'b1, 8'hFF, 16'd65535); // five digits
    send_req(clws_pkg::REQ_INT,  6'd5,  1'b0, 8'h00, 16'd105);   // inner zero kept
    send_req(clws_pkg::REQ_INT,  6'd7,  1'b1, 8'h00, 16'd10000); // trailing zeros kept
    send_req(clws_pkg::REQ_INT,  6'd63, 1'b0, 8'h00, 16'd10);
    send_req(clws_pkg::REQ_INT,  6'd40, 1'b1, 8'h00, 16'd9);
    send_req(clws_pkg::REQ_INT,  6'd2,  1'b0, 8'h00, 16'd60009);
    send_req(clws_pkg::REQ_INT,  6'd31, 1'b1, 8'h00, 16'd1000);
    for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
      send_req(3'(k), 6'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
    send_req(clws_pkg::REQ_INIT, 6'd0,  1'b0, 8'h00, 16'd0);
    send_req(clws_pkg::REQ_DATA, 6'd0,  1'b0, 8'h7E, 16'd0);

    // --- random requests over the idling phases ---
    // The receiver cannot hold writes off, so the phase that would stall it
    // runs with the sender free as well; the last phase idles it 29 percent.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 59 : (ph == 3) ? 29 : 0;
      counted  = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 10)      kind = clws_pkg::REQ_INIT;
        else if (pick < 22) kind = clws_pkg::REQ_CMD;
        else if (pick < 34) kind = clws_pkg::REQ_DATA;
        else if (pick < 56) kind = clws_pkg::REQ_CHAR;
        else if (pick < 94) kind = clws_pkg::REQ_INT;
        else                kind = 3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
        // mostly on the display, a fifth past the row end
        col = ($urandom_range(4) == 0) ? 6'($urandom_range(63, ROW_COLUMNS))
                                       : 6'($urandom_range(ROW_COLUMNS - 1));
        rw  = 1'($urandom);
        byt = 8'($urandom);
        pick = $urandom_range(7);
        if (pick == 0) begin
          num = 16'd0;
        end else if (pick == 1) begin
          num = 16'($urandom);
        end else if (pick < 4) begin
          // zero-heavy digits to work inner and trailing zeros
          num_i = 0;
          for (int d = 0; d < 5; d++)
            num_i = num_i * 10 + (($urandom_range(9) < 6) ? 0 : $urandom_range(9, 1));
          num = 16'(num_i % 65536);
        end else begin
          // even spread over digit counts
          ndig = $urandom_range(5, 1);
          num  = 16'($urandom_range((ndig == 5) ? 65535 : 10 ** ndig - 1, 10 ** (ndig - 1)));
        end
        send_req(kind, col, rw, byt, num);
        if (kind <= clws_pkg::REQ_INT) counted++;
      end
    end
    start <= 1'b0;

    // drain: every predicted write must arrive, then a quiet spell for strays
    while (writes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d display requests and %0d of unused kind; %0d bus writes checked.",
             reqs_sent, reqs_ignored, writes_checked);
    $display("Directed corners, then random requests with the sender idle 0/59/0/29 pct.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
